[rtl/rv32d_pkg.sv]
package rv32d_pkg;

    // Major opcodes, instruction bits 6:2
    localparam logic [4:0] OPC_LOAD     = 5'h00;
    localparam logic [4:0] OPC_CUSTOM_0 = 5'h02;
    localparam logic [4:0] OPC_MISC_MEM = 5'h03;
    localparam logic [4:0] OPC_OP_IMM   = 5'h04;
    localparam logic [4:0] OPC_AUIPC    = 5'h05;
    localparam logic [4:0] OPC_STORE    = 5'h08;
    localparam logic [4:0] OPC_AMO      = 5'h0B;
    localparam logic [4:0] OPC_OP       = 5'h0C;
    localparam logic [4:0] OPC_LUI      = 5'h0D;
    localparam logic [4:0] OPC_BRANCH   = 5'h18;
    localparam logic [4:0] OPC_JALR     = 5'h19;
    localparam logic [4:0] OPC_JAL      = 5'h1B;
    localparam logic [4:0] OPC_SYSTEM   = 5'h1C;

    // Low two bits of every uncompressed instruction
    localparam logic [1:0]  LEN_32BIT = 2'b11;
    localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] U_MASK    = 32'hFFFF_F000;

    typedef enum logic [2:0] {
        FMT_R = 3'd0,
        FMT_I = 3'd1,
        FMT_S = 3'd2,
        FMT_B = 3'd3,
        FMT_U = 3'd4,
        FMT_J = 3'd5
    } fmt_t;

    // Classifier status toward the immediate generator and result register
    typedef struct packed {
        logic illegal;
        fmt_t fmt;
    } fmt_info_t;

    // One decoded beat
    typedef struct packed {
        logic        illegal;
        fmt_t        fmt;
        logic [4:0]  major_opcode;
        logic [2:0]  funct3;
        logic [4:0]  funct5;
        logic [6:0]  funct7;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
    } result_t;

endpackage

[rtl/rv32_instruction_field_decoder.sv]
// Path: an accepted input beat goes through the input register, then the result register, to the output.
// Throughput: one instruction per cycle while out_stall is low; the input register feeds a single pass
// of shallow decode logic into the result register; each stage loads when it is empty or its beat moves on.
// Reset: rst_n (asynchronous, active low) empties both stages; payload registers
// are not cleared.
module rv32_instruction_field_decoder (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instruction_word,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        illegal,
    output logic [2:0]  format_code,
    output logic [4:0]  major_opcode,
    output logic [2:0]  funct3_field,
    output logic [4:0]  funct5_field,
    output logic [6:0]  funct7_field,
    output logic [4:0]  dest_reg,
    output logic [4:0]  src_reg_a,
    output logic [4:0]  src_reg_b,
    output logic [31:0] immediate
);

    // Stage 1: captured instruction word
    logic        in_vld_reg;
    logic [31:0] word_reg;

    // Stage 2: decoded result
    logic                res_vld_reg;
    rv32d_pkg::result_t  res_reg;
    rv32d_pkg::result_t  res_next;

    rv32d_pkg::fmt_info_t info;
    logic [31:0]          imm;

    logic res_load;
    logic in_load;

    // The result register takes a new beat whenever it is empty or its beat
    // leaves this cycle. The input register follows: it loads when it is empty
    // or when its beat moves into the result register.
    assign res_load = !res_vld_reg || !out_stall;
    assign in_load  = !in_vld_reg || res_load;
    assign in_stall = !in_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
        begin
            word_reg <= instruction_word;
        end
    end

    // Decode: classify the opcode, then pick the one immediate for that format
    rv32d_fmt_classify u_classify (
        .word (word_reg),
        .info (info)
    );

    rv32d_imm_gen u_imm_gen (
        .word (word_reg),
        .info (info),
        .imm  (imm)
    );

    // Raw slices pass through untouched, legal or not
    always_comb
    begin
        res_next.illegal      = info.illegal;
        res_next.fmt          = info.fmt;
        res_next.major_opcode = word_reg[6:2];
        res_next.funct3       = word_reg[14:12];
        res_next.funct5       = word_reg[31:27];
        res_next.funct7       = word_reg[31:25];
        res_next.rd           = word_reg[11:7];
        res_next.rs1          = word_reg[19:15];
        res_next.rs2          = word_reg[24:20];
        res_next.imm          = imm;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_vld_reg <= in_vld_reg;
        end
    end

    // Hold the result while stalled; advance only with a live beat behind it
    always_ff @(posedge clk)
    begin
        if (res_load && in_vld_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = res_vld_reg;
    assign illegal      = res_reg.illegal;
    assign format_code  = res_reg.fmt;
    assign major_opcode = res_reg.major_opcode;
    assign funct3_field = res_reg.funct3;
    assign funct5_field = res_reg.funct5;
    assign funct7_field = res_reg.funct7;
    assign dest_reg     = res_reg.rd;
    assign src_reg_a    = res_reg.rs1;
    assign src_reg_b    = res_reg.rs2;
    assign immediate    = res_reg.imm;

    // A bad word reports R format and a zero immediate
    a_illegal_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && illegal) |-> (format_code == rv32d_pkg::FMT_R && immediate == 32'd0))
        else $error("illegal result with nonzero format or immediate");

    // R-type carries no immediate
    a_r_zero_imm: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && format_code == rv32d_pkg::FMT_R) |-> (immediate == 32'd0))
        else $error("R-type result with nonzero immediate");

    // Branch and jump offsets are even, U immediates have a clear low part
    a_imm_low_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (format_code == rv32d_pkg::FMT_B || format_code == rv32d_pkg::FMT_J))
        |-> (immediate[0] == 1'b0))
        else $error("odd branch or jump offset");

    a_u_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && format_code == rv32d_pkg::FMT_U) |-> (immediate[11:0] == 12'd0))
        else $error("U immediate with nonzero low bits");

    // An accepted beat lands in the input register on the next edge
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_vld_reg)
        else $error("accepted beat lost at the input register");

endmodule

[rtl/rv32d_fmt_classify.sv]
module rv32d_fmt_classify (
    input  logic [31:0]          word,
    output rv32d_pkg::fmt_info_t info
);

    rv32d_pkg::fmt_t fmt;
    logic            known;

    always_comb
    begin
        known = 1'b1;
        fmt   = rv32d_pkg::FMT_R;
        case (word[6:2])
            rv32d_pkg::OPC_OP, rv32d_pkg::OPC_CUSTOM_0, rv32d_pkg::OPC_AMO:
                fmt = rv32d_pkg::FMT_R;
            rv32d_pkg::OPC_LOAD, rv32d_pkg::OPC_OP_IMM, rv32d_pkg::OPC_JALR,
            rv32d_pkg::OPC_SYSTEM, rv32d_pkg::OPC_MISC_MEM:
                fmt = rv32d_pkg::FMT_I;
            rv32d_pkg::OPC_STORE:
                fmt = rv32d_pkg::FMT_S;
            rv32d_pkg::OPC_BRANCH:
                fmt = rv32d_pkg::FMT_B;
            rv32d_pkg::OPC_LUI, rv32d_pkg::OPC_AUIPC:
                fmt = rv32d_pkg::FMT_U;
            rv32d_pkg::OPC_JAL:
                fmt = rv32d_pkg::FMT_J;
            default:
                known = 1'b0;
        endcase
    end

    always_comb
    begin
        info.illegal = (word == 32'd0) || (word == rv32d_pkg::WORD_ONES)
                    || (word[1:0] != rv32d_pkg::LEN_32BIT) || !known;
        // Force R format on a bad word so the immediate drops to zero
        info.fmt     = info.illegal ? rv32d_pkg::FMT_R : fmt;
    end

endmodule

[rtl/rv32d_imm_gen.sv]
module rv32d_imm_gen (
    input  logic [31:0]          word,
    input  rv32d_pkg::fmt_info_t info,
    output logic [31:0]          imm
);

    always_comb
    begin
        case (info.fmt)
            rv32d_pkg::FMT_I:
                imm = {{20{word[31]}}, word[31:20]};
            rv32d_pkg::FMT_S:
                imm = {{20{word[31]}}, word[31:25], word[11:7]};
            rv32d_pkg::FMT_B:
                imm = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
            rv32d_pkg::FMT_U:
                imm = word & rv32d_pkg::U_MASK;
            rv32d_pkg::FMT_J:
                imm = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
            default:
                imm = 32'd0;
        endcase
    end

endmodule
